// ===== rtl/lzom_pkg.sv =====
// ----------------------------------------------------------------------------
// Layer z-order manager package
//
// Shared field widths, operation and status codes, controller states and the
// command and status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lzom_pkg;

   localparam int MAX_LAYERS_DEFAULT = 256;

   localparam int FUNC_W       = 2;
   localparam int LAYER_W      = 8;
   localparam int HEIGHT_W     = 11;
   localparam int NEW_HEIGHT_W = 9;
   localparam int COUNT_W      = 9;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_DECIDE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FINISH,
      ST_RESP
   } lzom_state_type;

   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic look;
      logic decide;
      logic scan_rd;
      logic scan_chk;
      logic shift_rd;
      logic shift_wr;
      logic finish;
   } lzom_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_alloc;
      logic move;
      logic fin;
      logic scan_done;
      logic shift_done;
   } lzom_stat_type;

endpackage

// ===== rtl/lzom_ctrl.sv =====
// ----------------------------------------------------------------------------
// Layer z-order manager controller
//
// State machine that sequences the clearing pass, the lookup, the pool scan,
// the order table shift and the result transfer.
// ----------------------------------------------------------------------------
module lzom_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  lzom_pkg::lzom_stat_type stat,
   output lzom_pkg::lzom_cmd_type  cmd
);

   lzom_pkg::lzom_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzom_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lzom_pkg::ST_CLEAR: begin
            if (stat.clear_last) state_in = lzom_pkg::ST_IDLE;
         end
         lzom_pkg::ST_IDLE: begin
            if (req_valid) state_in = lzom_pkg::ST_LOOK;
         end
         lzom_pkg::ST_LOOK: begin
            state_in = lzom_pkg::ST_DECIDE;
         end
         lzom_pkg::ST_DECIDE: begin
            priority if (stat.is_alloc) state_in = lzom_pkg::ST_SCAN_RD;
            else if (stat.move)         state_in = lzom_pkg::ST_SHIFT_RD;
            else if (stat.fin)          state_in = lzom_pkg::ST_FINISH;
            else                        state_in = lzom_pkg::ST_RESP;
         end
         lzom_pkg::ST_SCAN_RD: begin
            state_in = lzom_pkg::ST_SCAN_CHK;
         end
         lzom_pkg::ST_SCAN_CHK: begin
            state_in = stat.scan_done ? lzom_pkg::ST_RESP : lzom_pkg::ST_SCAN_RD;
         end
         lzom_pkg::ST_SHIFT_RD: begin
            state_in = stat.shift_done ? lzom_pkg::ST_FINISH : lzom_pkg::ST_SHIFT_WR;
         end
         lzom_pkg::ST_SHIFT_WR: begin
            state_in = lzom_pkg::ST_SHIFT_RD;
         end
         lzom_pkg::ST_FINISH: begin
            state_in = lzom_pkg::ST_RESP;
         end
         lzom_pkg::ST_RESP: begin
            if (!rsp_stall) state_in = lzom_pkg::ST_IDLE;
         end
         default: begin
            state_in = lzom_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         lzom_pkg::ST_CLEAR:    cmd.clear_wr = 1'b1;
         lzom_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         lzom_pkg::ST_LOOK:     cmd.look     = 1'b1;
         lzom_pkg::ST_DECIDE:   cmd.decide   = 1'b1;
         lzom_pkg::ST_SCAN_RD:  cmd.scan_rd  = 1'b1;
         lzom_pkg::ST_SCAN_CHK: cmd.scan_chk = 1'b1;
         lzom_pkg::ST_SHIFT_RD: cmd.shift_rd = !stat.shift_done;
         lzom_pkg::ST_SHIFT_WR: cmd.shift_wr = 1'b1;
         lzom_pkg::ST_FINISH:   cmd.finish   = 1'b1;
         lzom_pkg::ST_RESP:     rsp_valid    = 1'b1;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/lzom_dpath.sv =====
// ----------------------------------------------------------------------------
// Layer z-order manager datapath
//
// Holds the layer information memory (in-use mark and height), the order table
// memory, the visible count and the item registers, and carries out the steps
// that the controller commands.
// ----------------------------------------------------------------------------
module lzom_dpath #(
   parameter int MAX_LAYERS = lzom_pkg::MAX_LAYERS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  lzom_pkg::lzom_cmd_type                   cmd,
   output lzom_pkg::lzom_stat_type                  stat,
   input  logic        [lzom_pkg::FUNC_W-1:0]       req_func,
   input  logic        [lzom_pkg::LAYER_W-1:0]      req_layer,
   input  logic signed [lzom_pkg::HEIGHT_W-1:0]     req_height,
   output logic                                     rsp_status,
   output logic        [lzom_pkg::LAYER_W-1:0]      rsp_layer_out,
   output logic signed [lzom_pkg::NEW_HEIGHT_W-1:0] rsp_new_height,
   output logic        [lzom_pkg::COUNT_W-1:0]      rsp_visible_count,
   output logic                                     rsp_redraw
);

   localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int HW = LW + 1;
   localparam int CW = ((lzom_pkg::HEIGHT_W > LW + 2) ? lzom_pkg::HEIGHT_W : LW + 2) + 1;
   localparam logic [LW-1:0]        LAST_IDX    = LW'(MAX_LAYERS - 1);
   localparam logic signed [CW-1:0] ONE_C       = CW'(1);
   localparam logic signed [CW-1:0] MINUS_ONE_C = CW'(-1);
   localparam logic signed [HW-1:0] HIDDEN_H    = '1;

   logic [HW:0]   info_mem [MAX_LAYERS];
   logic [LW-1:0] order_mem [MAX_LAYERS];
   logic [HW:0]   info_rd_ff;
   logic [LW-1:0] order_rd_ff;

   logic [lzom_pkg::FUNC_W-1:0]         func_ff, func_in;
   logic [lzom_pkg::LAYER_W-1:0]        layer_ff, layer_in;
   logic signed [lzom_pkg::HEIGHT_W-1:0] req_h_ff, req_h_in;
   logic signed [HW-1:0]                tgt_ff, tgt_in;
   logic signed [HW-1:0]                res_h_ff, res_h_in;
   logic [LW-1:0]                       dst_ff, dst_in;
   logic [LW-1:0]                       end_ff, end_in;
   logic                                dec_ff, dec_in;
   logic                                place_ff, place_in;
   logic                                free_ff, free_in;
   logic                                up_ff, up_in;
   logic                                dn_ff, dn_in;
   logic [LW-1:0]                       scan_ff, scan_in;
   logic [LW-1:0]                       clear_ff, clear_in;
   logic [LW:0]                         count_ff, count_in;
   logic                                status_ff, status_in;
   logic [lzom_pkg::LAYER_W-1:0]        layer_out_ff, layer_out_in;
   logic                                redraw_ff, redraw_in;

   logic [LW-1:0]        layer_idx;
   logic                 layer_ok;
   logic                 in_use;
   logic signed [HW-1:0] old_h;
   logic                 visible;
   logic                 is_alloc, is_set, is_free;
   logic signed [CW-1:0] top_c, old_c, req_c, lim_c, h_c;
   logic signed [HW-1:0] tgt_c, res_c;
   logic                 hide_c, move_c, fin_c, dec_c;
   logic [LW-1:0]        dst_c, end_c, src_c;
   logic                 scan_hit, scan_last;

   logic          info_we, info_re, order_we, order_re;
   logic [LW-1:0] info_wa, info_ra, order_wa, order_ra;
   logic [HW:0]   info_wd;
   logic [LW-1:0] order_wd;

   always_comb begin
      layer_idx = LW'(layer_ff);
      layer_ok  = int'(layer_ff) < MAX_LAYERS;
      in_use    = info_rd_ff[HW];
      old_h     = signed'(info_rd_ff[HW-1:0]);
      visible   = !old_h[HW-1];
      is_alloc  = func_ff == lzom_pkg::FUNC_ALLOC;
      is_set    = func_ff == lzom_pkg::FUNC_SET;
      is_free   = func_ff == lzom_pkg::FUNC_FREE;

      top_c = CW'(signed'({1'b0, count_ff})) - ONE_C;
      old_c = CW'(old_h);
      req_c = CW'(req_h_ff);
      lim_c = visible ? top_c : top_c + ONE_C;
      h_c   = req_c;
      if (h_c > lim_c) h_c = lim_c;
      if (h_c < MINUS_ONE_C) h_c = MINUS_ONE_C;

      tgt_c  = is_free ? HIDDEN_H : HW'(h_c);
      hide_c = tgt_c[HW-1];
      move_c = layer_ok && in_use && ((is_set && (h_c != old_c)) || (is_free && visible));
      fin_c  = is_set ? move_c : (is_free && layer_ok && in_use);
      dst_c  = visible ? old_h[LW-1:0] : count_ff[LW-1:0];
      end_c  = hide_c ? LW'(count_ff - 1'b1) : tgt_c[LW-1:0];
      dec_c  = !visible || (!hide_c && (tgt_c < old_h));
      res_c  = !layer_ok ? HIDDEN_H : (fin_c ? tgt_c : old_h);

      src_c     = dec_ff ? dst_ff - 1'b1 : dst_ff + 1'b1;
      scan_hit  = !info_rd_ff[HW];
      scan_last = scan_ff == LAST_IDX;
   end

   always_comb begin
      stat.clear_last = clear_ff == LAST_IDX;
      stat.is_alloc   = is_alloc;
      stat.move       = move_c;
      stat.fin        = fin_c;
      stat.scan_done  = scan_hit || scan_last;
      stat.shift_done = dst_ff == end_ff;
   end

   always_comb begin
      info_we  = 1'b0;
      info_wa  = clear_ff;
      info_wd  = {1'b0, HIDDEN_H};
      order_we = 1'b0;
      order_wa = dst_ff;
      order_wd = order_rd_ff;
      info_re  = cmd.look || cmd.scan_rd;
      info_ra  = cmd.look ? layer_idx : scan_ff;
      order_re = cmd.shift_rd;
      order_ra = src_c;
      unique if (cmd.clear_wr) begin
         info_we = 1'b1;
      end else if (cmd.scan_chk) begin
         info_we = scan_hit;
         info_wa = scan_ff;
         info_wd = {1'b1, HIDDEN_H};
      end else if (cmd.shift_wr) begin
         info_we  = 1'b1;
         info_wa  = order_rd_ff;
         info_wd  = {1'b1, 1'b0, dst_ff};
         order_we = 1'b1;
      end else if (cmd.finish) begin
         info_we  = 1'b1;
         info_wa  = layer_idx;
         info_wd  = {!free_ff, tgt_ff};
         order_we = place_ff;
         order_wa = tgt_ff[LW-1:0];
         order_wd = layer_idx;
      end else begin
         info_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (info_we) info_mem[info_wa] <= info_wd;
      if (info_re) info_rd_ff <= info_mem[info_ra];
   end

   always_ff @(posedge clock) begin
      if (order_we) order_mem[order_wa] <= order_wd;
      if (order_re) order_rd_ff <= order_mem[order_ra];
   end

   always_comb begin
      func_in      = func_ff;
      layer_in     = layer_ff;
      req_h_in     = req_h_ff;
      tgt_in       = tgt_ff;
      res_h_in     = res_h_ff;
      dst_in       = dst_ff;
      end_in       = end_ff;
      dec_in       = dec_ff;
      place_in     = place_ff;
      free_in      = free_ff;
      up_in        = up_ff;
      dn_in        = dn_ff;
      scan_in      = scan_ff;
      clear_in     = clear_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      layer_out_in = layer_out_ff;
      redraw_in    = redraw_ff;

      if (cmd.clear_wr) clear_in = clear_ff + 1'b1;
      if (cmd.capture) begin
         func_in  = req_func;
         layer_in = req_layer;
         req_h_in = req_height;
         scan_in  = '0;
      end
      if (cmd.decide) begin
         status_in    = lzom_pkg::STATUS_OK;
         layer_out_in = layer_ff;
         redraw_in    = move_c;
         res_h_in     = is_alloc ? HIDDEN_H : res_c;
         tgt_in       = tgt_c;
         dst_in       = dst_c;
         end_in       = end_c;
         dec_in       = dec_c;
         place_in     = move_c && !hide_c;
         free_in      = is_free;
         up_in        = move_c && !visible;
         dn_in        = move_c && hide_c;
      end
      if (cmd.scan_chk) begin
         priority if (scan_hit) begin
            status_in    = lzom_pkg::STATUS_OK;
            layer_out_in = lzom_pkg::LAYER_W'(scan_ff);
         end else if (scan_last) begin
            status_in    = lzom_pkg::STATUS_FULL;
            layer_out_in = '0;
         end else begin
            scan_in = scan_ff + 1'b1;
         end
      end
      if (cmd.shift_wr) dst_in = src_c;
      if (cmd.finish) begin
         priority if (up_ff) count_in = count_ff + 1'b1;
         else if (dn_ff)     count_in = count_ff - 1'b1;
         else                count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= '0;
         count_ff <= '0;
      end else begin
         clear_ff <= clear_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      layer_ff     <= layer_in;
      req_h_ff     <= req_h_in;
      tgt_ff       <= tgt_in;
      res_h_ff     <= res_h_in;
      dst_ff       <= dst_in;
      end_ff       <= end_in;
      dec_ff       <= dec_in;
      place_ff     <= place_in;
      free_ff      <= free_in;
      up_ff        <= up_in;
      dn_ff        <= dn_in;
      scan_ff      <= scan_in;
      status_ff    <= status_in;
      layer_out_ff <= layer_out_in;
      redraw_ff    <= redraw_in;
   end

   assign rsp_status        = status_ff;
   assign rsp_layer_out     = layer_out_ff;
   assign rsp_new_height    = lzom_pkg::NEW_HEIGHT_W'(res_h_ff);
   assign rsp_visible_count = lzom_pkg::COUNT_W'(count_ff);
   assign rsp_redraw        = redraw_ff;

endmodule

// ===== rtl/layer_z_order_manager_core.sv =====
// ----------------------------------------------------------------------------
// Layer z-order manager
//
// Allocates display layers from a pool, moves them within a bottom-to-top
// order of visible layers, and frees them.
//
//   Channel  Dir  Handshake             Payload
//   req      in   req_valid, req_stall  func, layer, height
//   rsp      out  rsp_valid, rsp_stall  status, layer_out, new_height, visible_count, redraw
//
// One item is worked on at a time. After the request transfer the layer entry is read and a
// decision made; then the pool is scanned entry by entry on allocate, or the order table is
// shifted entry by entry and the layer written when it moves, or only written when a hidden
// layer is freed, before the result is offered. The next request can be taken in the cycle
// after the result transfer. After reset a clearing pass over all MAX_LAYERS entries runs
// before the first request is taken. A stalled result holds until it is transferred.
// ----------------------------------------------------------------------------
module layer_z_order_manager_core #(
   parameter int MAX_LAYERS = lzom_pkg::MAX_LAYERS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic        [lzom_pkg::FUNC_W-1:0]       req_func,
   input  logic        [lzom_pkg::LAYER_W-1:0]      req_layer,
   input  logic signed [lzom_pkg::HEIGHT_W-1:0]     req_height,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_status,
   output logic        [lzom_pkg::LAYER_W-1:0]      rsp_layer_out,
   output logic signed [lzom_pkg::NEW_HEIGHT_W-1:0] rsp_new_height,
   output logic        [lzom_pkg::COUNT_W-1:0]      rsp_visible_count,
   output logic                                     rsp_redraw
);

   lzom_pkg::lzom_cmd_type  cmd;
   lzom_pkg::lzom_stat_type stat;

   lzom_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lzom_dpath #(
      .MAX_LAYERS (MAX_LAYERS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_layer         (req_layer),
      .req_height        (req_height),
      .rsp_status        (rsp_status),
      .rsp_layer_out     (rsp_layer_out),
      .rsp_new_height    (rsp_new_height),
      .rsp_visible_count (rsp_visible_count),
      .rsp_redraw        (rsp_redraw)
   );

   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("Result pending while the request side is open.");

   a_req_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Request side stayed open after a transfer.");

   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("Result presented again after its transfer.");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lzom_pkg::STATUS_FULL) |->
         !rsp_redraw && (&rsp_new_height) && (rsp_layer_out == '0))
      else $error("Pool full result carries a layer or a redraw.");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the layer z-order manager
//
// Drives allocate, set-height and free operations through the request channel
// and checks every result against an in-bench model of the layer pool and the
// bottom-to-top order. A short directed sequence is followed by a pass that
// fills the pool, shows and moves every layer and frees them all, and then by
// random churn with the pool partly in use. Both channels idle and stall at random, and
// the result channel is held off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   localparam int LAYERS = lzom_pkg::MAX_LAYERS_DEFAULT;
   localparam logic [lzom_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 2 * LAYERS + 20;

   typedef struct {
      logic [lzom_pkg::FUNC_W-1:0]          func;
      logic [lzom_pkg::LAYER_W-1:0]         layer;
      logic signed [lzom_pkg::HEIGHT_W-1:0] height;
      bit                                   calm;
   } layer_op_type;

   typedef struct {
      logic                                     status;
      logic [lzom_pkg::LAYER_W-1:0]             layer_out;
      logic signed [lzom_pkg::NEW_HEIGHT_W-1:0] new_height;
      logic [lzom_pkg::COUNT_W-1:0]             visible_count;
      logic                                     redraw;
   } layer_ack_type;

   logic                                     clock = 1'b0;
   logic                                     reset = 1'b1;
   logic                                     req_valid = 1'b0;
   logic                                     req_stall;
   logic [lzom_pkg::FUNC_W-1:0]              req_func = lzom_pkg::FUNC_ALLOC;
   logic [lzom_pkg::LAYER_W-1:0]             req_layer = '0;
   logic signed [lzom_pkg::HEIGHT_W-1:0]     req_height = '0;
   logic                                     rsp_valid;
   logic                                     rsp_stall = 1'b0;
   logic                                     rsp_status;
   logic [lzom_pkg::LAYER_W-1:0]             rsp_layer_out;
   logic signed [lzom_pkg::NEW_HEIGHT_W-1:0] rsp_new_height;
   logic [lzom_pkg::COUNT_W-1:0]             rsp_visible_count;
   logic                                     rsp_redraw;

   layer_op_type  pending_ops[$];
   layer_ack_type expected_acks[$];

   // In-bench copy of the pool and the order table.
   logic [lzom_pkg::LAYER_W-1:0] zo_slot[LAYERS];
   int                           zo_hgt[LAYERS];
   bit                           zo_used[LAYERS];
   int                           zo_top;

   // Stimulus-side tracking of which layers are in use and shown.
   bit gen_used[LAYERS];
   bit gen_shown[LAYERS];
   int gen_nused;
   int gen_nshown;
   int gen_last;

   int  ops_queued = 0;
   int  replies_seen = 0;
   int  errors = 0;
   int  n_alloc = 0;
   int  n_full = 0;
   int  n_redraw = 0;
   int  peak_visible = 0;
   bit  calm_mode = 1'b0;
   bit  quiet = 1'b0;
   bit  hold_ask = 1'b0;
   bit  hold_seen = 1'b0;
   int  send_gap = 0;
   int  stall_left = 0;
   layer_op_type  next_op;
   layer_ack_type want;

   layer_z_order_manager_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_layer         (req_layer),
      .req_height        (req_height),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_layer_out     (rsp_layer_out),
      .rsp_new_height    (rsp_new_height),
      .rsp_visible_count (rsp_visible_count),
      .rsp_redraw        (rsp_redraw)
   );

   always #5 clock = ~clock;

   function automatic void place(int slot, int lay);
      if (slot < 0 || slot >= LAYERS) return;
      zo_slot[slot] = lay[lzom_pkg::LAYER_W-1:0];
      zo_hgt[lay] = slot;
   endfunction

   function automatic bit shift_layer(int lay, int h);
      int old;
      int lim;
      int k;
      old = zo_hgt[lay];
      lim = (old < 0) ? zo_top + 1 : zo_top;
      if (h > lim) h = lim;
      if (h < -1) h = -1;
      if (h == old) return 1'b0;
      if (old > h) begin
         if (h >= 0) begin
            for (k = old; k > h; k--) place(k, int'(zo_slot[k-1]));
            place(h, lay);
         end else begin
            for (k = old; k < zo_top; k++) place(k, int'(zo_slot[k+1]));
            zo_hgt[lay] = -1;
            zo_top--;
         end
      end else begin
         if (old >= 0) begin
            for (k = old; k < h; k++) place(k, int'(zo_slot[k+1]));
            place(h, lay);
         end else begin
            for (k = zo_top; k >= h; k--) place(k + 1, int'(zo_slot[k]));
            place(h, lay);
            zo_top++;
         end
      end
      return 1'b1;
   endfunction

   function automatic layer_ack_type zorder_apply(logic [lzom_pkg::FUNC_W-1:0] f,
                                                  logic [lzom_pkg::LAYER_W-1:0] lay_in,
                                                  logic signed [lzom_pkg::HEIGHT_W-1:0] h_in);
      layer_ack_type ack;
      int lay;
      int i;
      int res_h;
      int vis;
      bit found;
      lay = int'(lay_in);
      res_h = -1;
      found = 1'b0;
      ack.status = lzom_pkg::STATUS_OK;
      ack.layer_out = lay_in;
      ack.redraw = 1'b0;
      case (f)
         lzom_pkg::FUNC_ALLOC: begin
            ack.layer_out = '0;
            ack.status = lzom_pkg::STATUS_FULL;
            for (i = 0; i < LAYERS && !found; i++) begin
               if (!zo_used[i]) begin
                  found = 1'b1;
                  zo_used[i] = 1'b1;
                  zo_hgt[i] = -1;
                  ack.layer_out = i[lzom_pkg::LAYER_W-1:0];
                  ack.status = lzom_pkg::STATUS_OK;
               end
            end
            n_alloc++;
            if (!found) n_full++;
         end
         lzom_pkg::FUNC_SET: begin
            if (zo_used[lay]) ack.redraw = shift_layer(lay, int'(h_in));
            res_h = zo_hgt[lay];
         end
         lzom_pkg::FUNC_FREE: begin
            if (zo_used[lay]) begin
               if (zo_hgt[lay] >= 0) ack.redraw = shift_layer(lay, -1);
               zo_used[lay] = 1'b0;
            end
            res_h = zo_hgt[lay];
         end
         default: res_h = zo_hgt[lay];
      endcase
      vis = zo_top + 1;
      ack.new_height = res_h[lzom_pkg::NEW_HEIGHT_W-1:0];
      ack.visible_count = vis[lzom_pkg::COUNT_W-1:0];
      if (ack.redraw) n_redraw++;
      if (vis > peak_visible) peak_visible = vis;
      return ack;
   endfunction

   // Driver: offers queued operations, holding each one while it is stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) expected_acks.push_back(zorder_apply(req_func, req_layer,
                                                                           req_height));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0 && !pending_ops[0].calm &&
                         $urandom_range(0, 6) == 0) begin
               send_gap <= $urandom_range(1, 11) - 1;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               next_op = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_func <= next_op.func;
               req_layer <= next_op.layer;
               req_height <= next_op.height;
               quiet <= next_op.calm;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer and drives the result stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_acks.size() == 0) begin
               $error("result transfer with no operation outstanding");
               errors++;
            end else begin
               want = expected_acks.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  errors++;
               end
               if (rsp_layer_out !== want.layer_out) begin
                  $error("layer_out: expected %0d, got %0d", want.layer_out, rsp_layer_out);
                  errors++;
               end
               if (rsp_new_height !== want.new_height) begin
                  $error("new_height: expected %0d, got %0d", want.new_height, rsp_new_height);
                  errors++;
               end
               if (rsp_visible_count !== want.visible_count) begin
                  $error("visible_count: expected %0d, got %0d", want.visible_count,
                         rsp_visible_count);
                  errors++;
               end
               if (rsp_redraw !== want.redraw) begin
                  $error("redraw: expected %0d, got %0d", want.redraw, rsp_redraw);
                  errors++;
               end
               replies_seen++;
            end
         end
         if (hold_ask && !hold_seen) begin
            hold_seen <= 1'b1;
            stall_left <= HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(1, 11) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic queue_op(input logic [lzom_pkg::FUNC_W-1:0] f, input int lay, input int h);
      layer_op_type op;
      int i;
      bit found;
      found = 1'b0;
      op.func = f;
      op.layer = lay[lzom_pkg::LAYER_W-1:0];
      op.height = h[lzom_pkg::HEIGHT_W-1:0];
      op.calm = calm_mode;
      pending_ops.push_back(op);
      ops_queued++;
      lay = lay % LAYERS;
      case (f)
         lzom_pkg::FUNC_ALLOC: begin
            for (i = 0; i < LAYERS && !found; i++) begin
               if (!gen_used[i]) begin
                  found = 1'b1;
                  gen_used[i] = 1'b1;
                  gen_nused++;
                  gen_last = i;
               end
            end
         end
         lzom_pkg::FUNC_SET: begin
            if (gen_used[lay] && gen_shown[lay] != (h >= 0)) begin
               gen_shown[lay] = (h >= 0);
               gen_nshown += (h >= 0) ? 1 : -1;
            end
         end
         lzom_pkg::FUNC_FREE: begin
            if (gen_used[lay]) begin
               if (gen_shown[lay]) gen_nshown--;
               gen_shown[lay] = 1'b0;
               gen_used[lay] = 1'b0;
               gen_nused--;
            end
         end
         default: ;
      endcase
   endtask

   function automatic int any_height();
      return int'($urandom_range(0, 2047)) - 1024;
   endfunction

   function automatic int pick_height();
      case ($urandom_range(0, 9))
         0: return any_height();
         1: return -1;
         2: return -2 - int'($urandom_range(0, 1022));
         3: return gen_nshown + int'($urandom_range(1, 1023 - gen_nshown));
         default: return int'($urandom_range(0, gen_nshown));
      endcase
   endfunction

   function automatic int pick_used();
      int i;
      int start;
      start = $urandom_range(0, LAYERS - 1);
      for (i = 0; i < LAYERS; i++) begin
         if (gen_used[(start + i) % LAYERS]) return (start + i) % LAYERS;
      end
      return start;
   endfunction

   task automatic wait_drained();
      while (replies_seen != ops_queued) @(posedge clock);
   endtask

   initial begin
      int i;
      int j;
      int n;
      int r;
      int tmp;
      int alloc_pct;
      int perm[LAYERS];

      for (i = 0; i < LAYERS; i++) begin
         zo_hgt[i] = -1;
         zo_used[i] = 1'b0;
         gen_used[i] = 1'b0;
         gen_shown[i] = 1'b0;
      end
      zo_top = -1;
      gen_nused = 0;
      gen_nshown = 0;
      gen_last = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: unused layers, unused code, clamping at both ends, unchanged
      // heights, moves to bottom and top, hiding, and freeing shown and hidden layers.
      queue_op(lzom_pkg::FUNC_FREE, 0, 0);
      queue_op(lzom_pkg::FUNC_SET, 5, 3);
      queue_op(FUNC_UNUSED, 0, 0);
      queue_op(lzom_pkg::FUNC_ALLOC, 0, 0);
      queue_op(lzom_pkg::FUNC_ALLOC, 255, 1023);
      queue_op(lzom_pkg::FUNC_ALLOC, 170, -1024);
      queue_op(lzom_pkg::FUNC_SET, 0, 1023);
      queue_op(lzom_pkg::FUNC_SET, 1, -1024);
      queue_op(lzom_pkg::FUNC_SET, 1, 0);
      queue_op(lzom_pkg::FUNC_SET, 2, 1);
      queue_op(lzom_pkg::FUNC_SET, 2, 1);
      queue_op(lzom_pkg::FUNC_SET, 0, 1023);
      queue_op(lzom_pkg::FUNC_SET, 1, 1023);
      queue_op(lzom_pkg::FUNC_SET, 1, 0);
      queue_op(lzom_pkg::FUNC_SET, 2, -1);
      queue_op(lzom_pkg::FUNC_SET, 0, -5);
      queue_op(lzom_pkg::FUNC_FREE, 1, 0);
      queue_op(lzom_pkg::FUNC_FREE, 1, 0);
      queue_op(FUNC_UNUSED, 2, 0);
      queue_op(lzom_pkg::FUNC_SET, 255, 0);
      queue_op(FUNC_UNUSED, 255, -1);
      queue_op(lzom_pkg::FUNC_ALLOC, 0, 0);
      queue_op(lzom_pkg::FUNC_FREE, 0, 0);
      wait_drained();

      // Fill the whole pool, show every layer, move them around, then free all.
      while (gen_nused < LAYERS) begin
         queue_op(lzom_pkg::FUNC_ALLOC, $urandom_range(0, 255), any_height());
         if ($urandom_range(0, 1)) queue_op(lzom_pkg::FUNC_SET, gen_last, pick_height());
      end
      for (i = 0; i < 3; i++)
         queue_op(lzom_pkg::FUNC_ALLOC, $urandom_range(0, 255), any_height());
      for (i = 0; i < LAYERS; i++) begin
         if (!gen_shown[i])
            queue_op(lzom_pkg::FUNC_SET, i,
                     $urandom_range(0, 1) ? 1023 : $urandom_range(0, gen_nshown));
      end
      for (i = 0; i < 60; i++) begin
         r = $urandom_range(0, 3);
         queue_op(lzom_pkg::FUNC_SET, $urandom_range(0, LAYERS - 1),
                  (r == 0) ? 1023 : (r == 1) ? pick_height() : $urandom_range(0, gen_nshown));
      end
      for (i = 0; i < LAYERS; i++) perm[i] = i;
      for (i = LAYERS - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = perm[i];
         perm[i] = perm[j];
         perm[j] = tmp;
      end
      for (i = 0; i < LAYERS; i++) queue_op(lzom_pkg::FUNC_FREE, perm[i], any_height());
      wait_drained();

      // Churn with the pool partly in use, with a long result hold-off at the start.
      for (n = 0; n < 700; n++) begin
         calm_mode = (n >= 550) || ((n / 80) % 4 == 2);
         r = $urandom_range(0, 99);
         alloc_pct = (gen_nused < 16) ? 35 : (gen_nused > 48) ? 5 : 15;
         if (r < alloc_pct)
            queue_op(lzom_pkg::FUNC_ALLOC, $urandom_range(0, 255), any_height());
         else if (r < alloc_pct + 12 && gen_nused > 0)
            queue_op(lzom_pkg::FUNC_FREE, pick_used(), any_height());
         else if (r < 90 && gen_nused > 0)
            queue_op(lzom_pkg::FUNC_SET, pick_used(), pick_height());
         else
            queue_op(lzom_pkg::FUNC_W'($urandom_range(1, 3)), $urandom_range(0, 255),
                     any_height());
      end
      hold_ask = 1'b1;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d operations: %0d allocations (%0d on a full pool), %0d order changes,",
               replies_seen, n_alloc, n_full, n_redraw);
      $display("with up to %0d layers visible at once.", peak_visible);
      if (errors == 0 && expected_acks.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("Timed out with %0d of %0d results received.", replies_seen, ops_queued);
      $display("tb NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lzom_pkg.sv
rtl/lzom_ctrl.sv
rtl/lzom_dpath.sv
rtl/layer_z_order_manager_core.sv
bench/tb.sv
